// ===== src/qtl_pkg.sv =====
`timescale 1ns / 1ps
// Package: payload types, CORDIC constants and helpers for the tilt leveling unit.
package qtl_pkg;

  localparam int AtanEntries = 24;
  localparam int CordicStepsDefault = 16;
  localparam int AngW = 34;
  localparam int VecW = 40;
  localparam int RotW = 34;
  localparam int SqW = 58;
  localparam int SqSteps = 29;
  localparam int SqPerStage = 4;
  localparam logic signed [AngW-1:0] QuarterTurn = AngW'(64'sd1073741824);
  localparam logic signed [RotW-1:0] GainInv = RotW'(64'sd652032874);
  localparam logic signed [33:0] OneQ28 = 34'sd268435456;

  typedef struct packed {
    logic              orient_valid;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } qtl_in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] level_w;
    logic signed [15:0] level_x;
    logic signed [15:0] level_y;
    logic signed [15:0] level_z;
  } qtl_out_t;

  function automatic logic signed [AngW-1:0] atan_step(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41721;     5'd15: r = 34'sd20860;
      5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2607;      5'd19: r = 34'sd1303;
      5'd20: r = 34'sd651;       5'd21: r = 34'sd325;
      5'd22: r = 34'sd162;       5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round internal angle (2^32 = 2 pi) to a 16-bit binary angle, half up.
  function automatic logic signed [17:0] to_ang16(input logic signed [AngW-1:0] a);
    logic signed [AngW:0] t;
    t = {a[AngW-1], a} + (AngW+1)'(32768);
    return 18'(t >>> 16);
  endfunction

  // Product of two 2^30-scaled values to Q1.14, rounded and limited.
  function automatic logic signed [15:0] prod_q14(input logic signed [RotW-1:0] a,
                                                  input logic signed [RotW-1:0] b);
    logic signed [2*RotW-1:0] p;
    logic signed [2*RotW-47:0] r;
    p = a * b + (2*RotW)'(64'sd35184372088832);
    r = p[2*RotW-1:46];
    if (r > 16384) return 16'sd16384;
    if (r < -16384) return -16'sd16384;
    return 16'(r);
  endfunction

endpackage

// ===== src/quaternion_tilt_level_unit.sv =====
`timescale 1ns / 1ps
// Top level: quaternion to roll/pitch and leveling quaternion, fully pipelined.
//
// Accepts one orientation transaction every clock unless in_stall_o is high, and
// returns one result transaction per input, in order. The pipe is 2*CORDIC_STEPS+13
// register stages deep (CORDIC_STEPS capped at 24): component products, square of the
// pitch term, an 8-stage square root that the roll terms ride through alongside,
// vectoring pre-rotation, CORDIC_STEPS vectoring stages for roll and pitch side by
// side, rounding, CORDIC_STEPS rotation stages for both half angles, and the output
// register that takes the final products. One CORDIC iteration or up to four root
// bits sit in each of those stages. A stall from downstream freezes every stage at
// once, so nothing is lost or repeated; the output register keeps the last result
// while in_stall_o is high.
module quaternion_tilt_level_unit #(
  parameter int CORDIC_STEPS = qtl_pkg::CordicStepsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  qtl_pkg::qtl_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output qtl_pkg::qtl_out_t out_data_o
);
  import qtl_pkg::*;

  localparam int NSteps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam int SqStages = (SqSteps + SqPerStage - 1) / SqPerStage;
  // Stage sequence: 1 product, 1 square, SqStages root, 1 pre-rotate,
  // NSteps vectoring (roll and pitch), 1 round, NSteps rotation, out reg.
  // Pitch vectoring starts after the root, so roll waits by delaying.
  localparam int VecStart = 2 + SqStages;
  localparam int Depth = VecStart + 1 + NSteps + 1 + NSteps + 1;

  logic adv;
  assign adv = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Valid travels with every stage.
  logic [Depth-1:0] vld_q;

  // ---- stage 1: products ----
  logic                  p_ov_q;
  logic signed [33:0]    p_sinr_q, p_cosr_q, p_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_ov_q   <= in_data_i.orient_valid;
      p_sinr_q <= 34'(2 * (34'(in_data_i.quat_w) * 34'(in_data_i.quat_x)
                       + 34'(in_data_i.quat_y) * 34'(in_data_i.quat_z)));
      p_cosr_q <= OneQ28 - 34'(2 * (34'(in_data_i.quat_x) * 34'(in_data_i.quat_x)
                       + 34'(in_data_i.quat_y) * 34'(in_data_i.quat_y)));
      p_s_q    <= 34'(2 * (34'(in_data_i.quat_w) * 34'(in_data_i.quat_y)
                       - 34'(in_data_i.quat_z) * 34'(in_data_i.quat_x)));
    end
  end

  // ---- square root stages: floor(sqrt(2^56 - s*s)), up to four bits a stage ----
  logic [SqW-1:0]      sq_n_q   [SqStages+1];
  logic [SqW-1:0]      sq_r_q   [SqStages+1];
  logic signed [33:0]  sq_sinr_q[SqStages+1];
  logic signed [33:0]  sq_cosr_q[SqStages+1];
  logic signed [33:0]  sq_s_q   [SqStages+1];
  logic                sq_ov_q  [SqStages+1];
  logic [1:0]          sq_sat_q [SqStages+1];  // [1]=sat, [0]=negative

  // Square the pitch term in its own stage.
  always_ff @(posedge clk_i) begin
    logic [67:0] ss;
    ss = 68'(p_s_q) * 68'(p_s_q);
    if (adv) begin
      sq_n_q[0]    <= (SqW)'(58'h100000000000000 - ss[57:0]);
      sq_r_q[0]    <= '0;
      sq_sinr_q[0] <= p_sinr_q;
      sq_cosr_q[0] <= p_cosr_q;
      sq_s_q[0]    <= p_s_q;
      sq_ov_q[0]   <= p_ov_q;
      sq_sat_q[0]  <= {(p_s_q >= OneQ28) || (p_s_q <= -OneQ28), p_s_q[33]};
    end
  end

  for (genvar g = 0; g < SqStages; g++) begin : g_sqrt
    logic [SqW-1:0] n_d, r_d;
    always_comb begin
      logic [SqW+1:0] trial;
      n_d = sq_n_q[g];
      r_d = sq_r_q[g];
      trial = '0;
      for (int k = 0; k < SqPerStage; k++) begin
        if (g * SqPerStage + k < SqSteps) begin
          // Restoring step on bit pair from the top.
          trial = (SqW+2)'(r_d << 2) | (SqW+2)'(1);
          if ((SqW+2)'(n_d >> (2 * (SqSteps - 1 - (g * SqPerStage + k)))) >= trial) begin
            n_d = n_d - SqW'(trial[SqW-1:0] << (2 * (SqSteps - 1 - (g * SqPerStage + k))));
            r_d = (r_d << 1) | SqW'(1);
          end else begin
            r_d = r_d << 1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_n_q[g+1]    <= n_d;
        sq_r_q[g+1]    <= r_d;
        sq_sinr_q[g+1] <= sq_sinr_q[g];
        sq_cosr_q[g+1] <= sq_cosr_q[g];
        sq_s_q[g+1]    <= sq_s_q[g];
        sq_ov_q[g+1]   <= sq_ov_q[g];
        sq_sat_q[g+1]  <= sq_sat_q[g];
      end
    end
  end

  // ---- vectoring CORDIC, roll and pitch lanes ----
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } vec_t;

  vec_t vr_q [NSteps+1];
  vec_t vp_q [NSteps+1];
  logic vo_q [NSteps+1];
  logic [1:0] vs_q [NSteps+1];

  function automatic vec_t vec_pre(input logic signed [VecW-1:0] xi,
                                   input logic signed [VecW-1:0] yi);
    vec_t r;
    r.x = xi; r.y = yi; r.z = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        r.x = yi; r.y = -xi; r.z = QuarterTurn;
      end else begin
        r.x = -yi; r.y = xi; r.z = -QuarterTurn;
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vr_q[0] <= vec_pre(VecW'(sq_cosr_q[SqStages]), VecW'(sq_sinr_q[SqStages]));
      vp_q[0] <= vec_pre(VecW'(sq_r_q[SqStages]), VecW'(sq_s_q[SqStages]));
      vo_q[0] <= sq_ov_q[SqStages];
      vs_q[0] <= sq_sat_q[SqStages];
    end
  end

  function automatic vec_t vec_it(input vec_t v, input int i);
    vec_t r;
    r = v;
    if (v.y >= 0) begin
      r.x = v.x + (v.y >>> i); r.y = v.y - (v.x >>> i);
      r.z = v.z + atan_step(5'(i));
    end else begin
      r.x = v.x - (v.y >>> i); r.y = v.y + (v.x >>> i);
      r.z = v.z - atan_step(5'(i));
    end
    return r;
  endfunction

  for (genvar g = 0; g < NSteps; g++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (adv) begin
        vr_q[g+1] <= vec_it(vr_q[g], g);
        vp_q[g+1] <= vec_it(vp_q[g], g);
        vo_q[g+1] <= vo_q[g];
        vs_q[g+1] <= vs_q[g];
      end
    end
  end

  // ---- round to binary angles ----
  logic signed [15:0] roll_q, pitch_q;
  logic               ro_q;

  always_ff @(posedge clk_i) begin
    logic signed [17:0] ra, pa;
    vec_t vr, vp;
    vr = vr_q[NSteps];
    vp = vp_q[NSteps];
    ra = ((vr.x == 0) && (vr.y == 0)) ? 18'sd0 : to_ang16(vr.z);
    pa = ((vp.x == 0) && (vp.y == 0)) ? 18'sd0 : to_ang16(vp.z);
    if (pa > 16384) pa = 18'sd16384;
    if (pa < -16384) pa = -18'sd16384;
    if (vs_q[NSteps][1]) pa = vs_q[NSteps][0] ? -18'sd16384 : 18'sd16384;
    if (adv) begin
      roll_q  <= 16'(ra);
      pitch_q <= 16'(pa);
      ro_q    <= vo_q[NSteps];
    end
  end

  // ---- rotation CORDIC for both half angles ----
  typedef struct packed {
    logic signed [RotW-1:0] x;
    logic signed [RotW-1:0] y;
    logic signed [AngW-1:0] z;
  } rot_t;

  rot_t rr_q [NSteps+1];
  rot_t rp_q [NSteps+1];
  logic signed [15:0] rra_q [NSteps+1];
  logic signed [15:0] rpa_q [NSteps+1];
  logic ro2_q [NSteps+1];

  function automatic rot_t rot_it(input rot_t v, input int i);
    rot_t r;
    r = v;
    if (v.z >= 0) begin
      r.x = v.x - (v.y >>> i); r.y = v.y + (v.x >>> i);
      r.z = v.z - atan_step(5'(i));
    end else begin
      r.x = v.x + (v.y >>> i); r.y = v.y - (v.x >>> i);
      r.z = v.z + atan_step(5'(i));
    end
    return r;
  endfunction

  always_comb begin
    rr_q[0].x = GainInv; rr_q[0].y = '0;
    rr_q[0].z = -(AngW'(roll_q) <<< 15);
    rp_q[0].x = GainInv; rp_q[0].y = '0;
    rp_q[0].z = -(AngW'(pitch_q) <<< 15);
    rra_q[0] = roll_q;
    rpa_q[0] = pitch_q;
    ro2_q[0] = ro_q;
  end

  for (genvar g = 0; g < NSteps; g++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rr_q[g+1]  <= rot_it(rr_q[g], g);
        rp_q[g+1]  <= rot_it(rp_q[g], g);
        rra_q[g+1] <= rra_q[g];
        rpa_q[g+1] <= rpa_q[g];
        ro2_q[g+1] <= ro2_q[g];
      end
    end
  end

  // ---- final products and output register ----
  qtl_out_t res_d, out_q;

  always_comb begin
    if (!ro2_q[NSteps]) begin
      res_d = '{roll_angle: '0, pitch_angle: '0, level_w: 16'sd16384,
                level_x: '0, level_y: '0, level_z: '0};
    end else begin
      res_d.roll_angle  = rra_q[NSteps];
      res_d.pitch_angle = rpa_q[NSteps];
      res_d.level_w = prod_q14(rr_q[NSteps].x, rp_q[NSteps].x);
      res_d.level_x = prod_q14(rr_q[NSteps].y, rp_q[NSteps].x);
      res_d.level_y = prod_q14(rr_q[NSteps].x, rp_q[NSteps].y);
      res_d.level_z = -prod_q14(rr_q[NSteps].y, rp_q[NSteps].y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q)) else $error("pipeline moved under stall");
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i)) else $error("stall mismatch");
  a_pitch_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pitch_angle <= 16384 && out_data_o.pitch_angle >= -16384))
    else $error("pitch out of range");
`endif

endmodule

// ===== test/quaternion_tilt_level_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench: tilt leveling unit checked against a bit-exact CORDIC predictor.
module quaternion_tilt_level_unit_tb;
  import qtl_pkg::*;

  localparam int Steps = 16;
  localparam int Latency = 2 * Steps + 13;
  localparam int NumRandom = 300;
  localparam longint CycleLimit = 200000;
  localparam longint OneQ28L = 64'sd268435456;
  localparam longint QuarterL = 64'sd1073741824;

  // Drive mode per phase: how often each side idles.
  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  qtl_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  qtl_out_t out_data_o;

  quaternion_tilt_level_unit #(.CORDIC_STEPS(Steps)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bit-exact predictor of the leveling math.
  longint atan_lut [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81};

  qtl_out_t level_q[$];
  int mismatch_cnt = 0;
  int result_cnt = 0;
  longint cycle_cnt = 0;
  idle_mode_e idle_mode = IdleNone;
  bit hold_off = 1'b0;
  int sat_cnt = 0;

  // Vectoring CORDIC: angle of (y, x) at 2^32 per turn.
  function automatic longint angle_of(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QuarterL;
      end else begin
        t = x; x = -y; y = t; z = -QuarterL;
      end
    end
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  // Rotation CORDIC: cosine and sine at 2^30 scale.
  function automatic void half_sincos(input longint a, output longint c, output longint s);
    longint dx, dy;
    c = 652032874;
    s = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = s >>> i;
      dy = c >>> i;
      if (a >= 0) begin
        c -= dx; s += dy; a -= atan_lut[i];
      end else begin
        c += dx; s -= dy; a += atan_lut[i];
      end
    end
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint scale_q14(longint a, longint b);
    longint r;
    r = (a * b + (64'sd1 <<< 45)) >>> 46;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic qtl_out_t predict_level(qtl_in_t q);
    qtl_out_t o;
    longint w, x, y, z, sinr, cosr, s, roll, pitch, cr, sr, cp, sp;
    logic signed [15:0] r16;
    o = '0;
    if (!q.orient_valid) begin
      o.level_w = 16'sd16384;
      return o;
    end
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    sinr = 2 * (w * x + y * z);
    cosr = OneQ28L - 2 * (x * x + y * y);
    // Roll of pi wraps to -pi through the 16-bit truncation.
    r16 = 16'((angle_of(sinr, cosr) + 32768) >>> 16);
    roll = r16;
    s = 2 * (w * y - z * x);
    if (s >= OneQ28L) pitch = 16384;
    else if (s <= -OneQ28L) pitch = -16384;
    else begin
      pitch = (angle_of(s, root_floor((64'd1 << 56) - s * s)) + 32768) >>> 16;
      if (pitch > 16384) pitch = 16384;
      if (pitch < -16384) pitch = -16384;
    end
    half_sincos(-roll * 32768, cr, sr);
    half_sincos(-pitch * 32768, cp, sp);
    o.roll_angle = 16'(roll);
    o.pitch_angle = 16'(pitch);
    o.level_w = 16'(scale_q14(cr, cp));
    o.level_x = 16'(scale_q14(sr, cp));
    o.level_y = 16'(scale_q14(cr, sp));
    o.level_z = 16'(-scale_q14(sr, sp));
    return o;
  endfunction

  function automatic qtl_in_t make_quat(bit v, int w, int x, int y, int z);
    qtl_in_t q;
    q.orient_valid = v;
    q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
    return q;
  endfunction

  // Directed table; has_gold marks rows whose result is typed in.
  typedef struct {
    qtl_in_t  q;
    bit       has_gold;
    qtl_out_t gold;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic qtl_out_t gold_of(int r, int p, int w, int x, int y, int z);
    qtl_out_t o;
    o.roll_angle = 16'(r); o.pitch_angle = 16'(p);
    o.level_w = 16'(w); o.level_x = 16'(x); o.level_y = 16'(y); o.level_z = 16'(z);
    return o;
  endfunction

  task automatic add_row(qtl_in_t q, bit g = 0, qtl_out_t o = '0);
    dir_row_t r;
    r.q = q; r.has_gold = g; r.gold = o;
    dir_tab.push_back(r);
  endtask

  // Random orientation: mostly near-unit quaternions, some raw noise.
  function automatic qtl_in_t rand_quat();
    qtl_in_t q;
    int sel;
    real a, b, c, d, n;
    sel = $urandom_range(0, 99);
    if (sel < 5) return make_quat(0, $urandom, $urandom, $urandom, $urandom);
    if (sel < 20) begin
      q = qtl_in_t'({1'b1, 64'($urandom) << 32 | 64'($urandom)});
      return q;
    end
    if (sel < 30) begin
      // Near gimbal lock: w = y, x = z = 0 style pitch saturation.
      a = 11585.0 + $urandom_range(0, 40) - 20.0;
      return make_quat(1, int'(a), $urandom_range(0, 8), int'(a), $urandom_range(0, 8));
    end
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) n = 1.0;
    return make_quat(1, int'(a * 16384.0 / n), int'(b * 16384.0 / n),
                     int'(c * 16384.0 / n), int'(d * 16384.0 / n));
  endfunction

  // Offer one transaction; hold it until accepted, then in sender-idle modes idle randomly.
  task automatic send_quat(qtl_in_t q);
    int pct;
    pct = (idle_mode == IdleBoth) ? 14 : 71;
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    level_q.push_back(predict_level(q));
    if (idle_mode == IdleSender || idle_mode == IdleBoth) begin
      while ($urandom_range(0, 99) < pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (idle_mode == IdleReceiver) out_stall_i <= ($urandom_range(0, 99) < 71);
    else if (idle_mode == IdleBoth) out_stall_i <= ($urandom_range(0, 99) < 14);
    else out_stall_i <= 1'b0;
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    qtl_out_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (level_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_o = level_q.pop_front();
        if (exp_o !== out_data_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: expected %p actual %p", exp_o, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout with %0d results pending", level_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int drain;
    qtl_in_t q;
    // Identity, no orientation, extremes, pitch saturation, roll of pi, zero vector.
    add_row(make_quat(0, 16384, 0, 0, 0), 1, gold_of(0, 0, 16384, 0, 0, 0));
    add_row(make_quat(0, -32768, 32767, -1, 5), 1, gold_of(0, 0, 16384, 0, 0, 0));
    add_row(make_quat(1, 16384, 0, 0, 0));
    add_row(make_quat(1, -16384, 0, 0, 0));
    add_row(make_quat(1, 0, 16384, 0, 0));
    add_row(make_quat(1, 0, 0, 16384, 0));
    add_row(make_quat(1, 0, 0, 0, 16384));
    add_row(make_quat(1, 11585, 0, 11585, 0));
    add_row(make_quat(1, 11585, 0, -11585, 0));
    add_row(make_quat(1, 16384, 0, 16384, 0));
    add_row(make_quat(1, 0, 11585, 0, 11585));
    add_row(make_quat(1, 0, 0, 0, 0));
    add_row(make_quat(1, 11585, 11585, 0, 0));
    add_row(make_quat(1, -32768, -32768, -32768, -32768));
    add_row(make_quat(1, 32767, 32767, 32767, 32767));
    add_row(make_quat(1, -32768, 32767, 32767, -32768));
    add_row(make_quat(1, 8192, 8192, 8192, 8192));
    add_row(make_quat(1, 1, -1, 1, -1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_quat(dir_tab[i].q);
      if (dir_tab[i].has_gold) level_q[$] = dir_tab[i].gold;
    end

    // Long receiver hold-off while items keep coming, to back up the pipe.
    fork
      begin
        hold_off = 1'b1;
        repeat (3 * Latency) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++) send_quat(rand_quat());
    join

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      for (int i = 0; i < NumRandom / 4; i++) begin
        q = rand_quat();
        if (q.orient_valid && q.quat_w == q.quat_y) sat_cnt++;
        send_quat(q);
      end
    end
    in_valid_i <= 1'b0;
    idle_mode = IdleNone;

    drain = 0;
    while (level_q.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (Latency + 10) @(posedge clk_i);

    $display("checked %0d leveling results over four idle patterns and a long hold-off",
             result_cnt);
    $display("%0d near gimbal-lock inputs; %0d mismatches, %0d results left waiting",
             sat_cnt, mismatch_cnt, level_q.size());
    if (mismatch_cnt == 0 && level_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
